/* design/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the byte-wide CRC-16/XMODEM update for the
// control frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  // frame layout: header, four data bytes, crc high, crc low
  localparam int unsigned BODY_LEN  = 5;
  localparam int unsigned FRAME_LEN = 7;
  localparam int unsigned IDX_W     = 3;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t CRC_HI_IDX = idx_t'(BODY_LEN);
  localparam idx_t CRC_LO_IDX = idx_t'(FRAME_LEN - 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // one command as taken from the input channel
  typedef struct packed {
    logic [3:0]         channel;
    logic [3:0]         payload_type;
    logic signed [31:0] data_word;
  } cmd_t;

  // msb-first crc update over one byte, no augmentation needed
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/cfb_if.sv */
// ----------------------------------------------------------------------------
// cfb_if
// Valid/ready channel interfaces for commands in and frame bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic [3:0]         payload_type;
  logic signed [31:0] data_word;

  modport source (output valid, output channel, output payload_type,
                  output data_word, input ready);
  modport sink   (input valid, input channel, input payload_type,
                  input data_word, output ready);
endinterface

interface cfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input frame_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

/* design/control_frame_builder_crc16_top.sv */
// ----------------------------------------------------------------------------
// control_frame_builder_crc16_top
// Turns each command into a seven-byte frame protected by CRC-16/XMODEM.
// ----------------------------------------------------------------------------
// Each command transfer on cmd produces seven byte transfers on frame: the
// header {channel, payload_type}, data_word most significant byte first,
// then the crc high and low bytes, with last_byte set on the final one.
// One command is taken into an input register and then loaded into the
// serializer's byte registers, from which the first byte is sent. The
// byte-wide frame channel sets the rate, with the next command waiting in
// the input register while a frame drains. The crc is updated one byte per
// cycle as each body byte is sent, holding while frame.ready is low.
`default_nettype none

module control_frame_builder_crc16_top
  import cfb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  cfb_cmd_if.sink     cmd,
  cfb_frame_if.source frame
);

  logic pend;
  cmd_t cmd_reg;
  logic load_ready;

  assign cmd.ready = !pend;

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.valid && !pend) begin
      pend <= 1'b1;
    end else if (load_ready) begin
      pend <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (cmd.valid && !pend) begin
      cmd_reg.channel      <= cmd.channel;
      cmd_reg.payload_type <= cmd.payload_type;
      cmd_reg.data_word    <= cmd.data_word;
    end
  end

  cfb_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (pend),
    .load_cmd   (cmd_reg),
    .load_ready (load_ready),
    .frame      (frame)
  );

endmodule

`default_nettype wire

/* design/cfb_serializer.sv */
// ----------------------------------------------------------------------------
// cfb_serializer
// Holds one command frame and sends it a byte per transfer, updating the
// crc as each body byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_serializer
  import cfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load_valid,
  input  wire cmd_t  load_cmd,
  output logic       load_ready,
  cfb_frame_if.source frame
);

  logic        busy;
  idx_t        idx;
  logic [7:0]  body [BODY_LEN];
  logic [15:0] crc;

  logic [7:0]  cur_byte;
  logic        is_last;
  logic        xfer;
  logic        load;

  // byte select for the current position
  always_comb begin
    case (idx)
      CRC_HI_IDX: cur_byte = crc[15:8];
      CRC_LO_IDX: cur_byte = crc[7:0];
      default:    cur_byte = body[idx];
    endcase
  end

  assign is_last          = (idx == CRC_LO_IDX);
  assign frame.valid      = busy;
  assign frame.frame_byte = cur_byte;
  assign frame.last_byte  = is_last;

  assign xfer       = busy && frame.ready;
  assign load_ready = !busy || (xfer && is_last);
  assign load       = load_valid && load_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      idx <= idx + idx_t'(1);
      if (is_last) begin
        busy <= 1'b0;
      end
    end
  end

  // frame bytes and running crc
  always_ff @(posedge clk) begin
    if (load) begin
      body[0] <= {load_cmd.channel, load_cmd.payload_type};
      body[1] <= load_cmd.data_word[31:24];
      body[2] <= load_cmd.data_word[23:16];
      body[3] <= load_cmd.data_word[15:8];
      body[4] <= load_cmd.data_word[7:0];
      crc     <= CRC_INIT;
    end else if (xfer && (idx < CRC_HI_IDX)) begin
      crc <= crc16_byte(crc, cur_byte);
    end
  end

endmodule

`default_nettype wire
